@@ design/hgs_pkg.sv @@
// Shared types, request/register codes and constants for the Hopfield graph settle block.
package hgs_pkg;

    localparam int DEF_MAX_NODES   = 1024;
    localparam int DEF_MAX_EDGES   = 4096;
    localparam int DEF_SWEEP_LIMIT = 5000;

    localparam int ACC_W = 48;
    localparam int OFS_W = 13;

    localparam logic [2:0] REQ_WRITE_NODE = 3'd0;
    localparam logic [2:0] REQ_WRITE_EDGE = 3'd1;
    localparam logic [2:0] REQ_SET_STATE  = 3'd2;
    localparam logic [2:0] REQ_RUN        = 3'd3;
    localparam logic [2:0] REQ_READ_STATE = 3'd4;
    localparam logic [2:0] REQ_CLEAR      = 3'd5;

    localparam logic [1:0] REG_NUM_NODES = 2'd0;
    localparam logic [1:0] REG_POS_STATE = 2'd1;
    localparam logic [1:0] REG_NEG_STATE = 2'd2;
    localparam logic [1:0] REG_REGUL     = 2'd3;

    localparam logic RESP_READOUT = 1'b0;
    localparam logic RESP_RUN     = 1'b1;

    localparam logic signed [15:0] POS_STATE_RST = 16'sd256;
    localparam logic signed [15:0] NEG_STATE_RST = -16'sd256;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [10:0]        node_index;
        logic [11:0]        edge_index;
        logic signed [15:0] threshold;
        logic [12:0]        edge_start;
        logic [9:0]         neighbor;
        logic signed [15:0] weight;
        logic signed [15:0] init_state;
    } req_t;

    typedef struct packed {
        logic               resp_kind;
        logic signed [15:0] node_state;
        logic [12:0]        sweeps;
        logic               hit_limit;
        logic signed [47:0] energy;
    } resp_t;

    typedef struct packed {
        logic clr;
        logic mul;
        logic add;
    } mac_ctl_t;

endpackage

@@ design/hgs_mac.sv @@
// Shared multiply-accumulate unit: registered 17x16 product, 48-bit accumulator.
module hgs_mac
    import hgs_pkg::*;
(
    input  logic                    aclk,
    input  mac_ctl_t                ctl,
    input  logic signed [16:0]      op_a,
    input  logic signed [15:0]      op_b,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [32:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (ctl.mul) begin
            prod_reg <= op_a * op_b;
        end
        if (ctl.clr) begin
            acc_reg <= '0;
        end else if (ctl.add) begin
            acc_reg <= acc_reg + {{(ACC_W-33){prod_reg[32]}}, prod_reg};
        end
    end

    assign acc = acc_reg;

endmodule

@@ design/hopfield_graph_settle.sv @@
// Top level: graph stores, request sequencer, config registers and result register.
//
// Asynchronous Hopfield settle over a graph in compressed-row form. Write node,
// write edge, set state and clear requests are taken one per cycle in idle, except
// clear, which then zeroes each node in use in turn. A read state transaction reads
// the states store, then loads its result into the output register once it is free.
// A run walks nodes 0..n-1 in order on one shared multiply-accumulate unit; each sweep
// does per node a node read, threshold multiply and add, then per edge an edge read,
// neighbor state read, multiply and accumulate, then the decision; one more pass of
// the same kind gives the energy. The states store is swept to zero after reset,
// during which no request is accepted; config writes are taken at any time. The
// input side is not ready while a run, clear or readout is in progress. A result
// waits in the output register; further load requests are accepted meanwhile.
module hopfield_graph_settle
    import hgs_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int MAX_EDGES   = DEF_MAX_EDGES,
    parameter int SWEEP_LIMIT = DEF_SWEEP_LIMIT
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  req_t        s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output resp_t       m_data
);

    localparam int NA   = $clog2(MAX_NODES);
    localparam int OA   = $clog2(MAX_NODES + 1);
    localparam int NC_W = OA;
    localparam int EA   = $clog2(MAX_EDGES);
    localparam int SW_W = $clog2(SWEEP_LIMIT + 2);

    localparam logic [3:0] ST_CLR    = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_RDATA  = 4'd2;
    localparam logic [3:0] ST_NODE   = 4'd3;
    localparam logic [3:0] ST_NODE2  = 4'd4;
    localparam logic [3:0] ST_NADD   = 4'd5;
    localparam logic [3:0] ST_ERD    = 4'd6;
    localparam logic [3:0] ST_SRD    = 4'd7;
    localparam logic [3:0] ST_MUL    = 4'd8;
    localparam logic [3:0] ST_ADD    = 4'd9;
    localparam logic [3:0] ST_DECIDE = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    // config registers
    logic [10:0]        num_nodes_reg;
    logic signed [15:0] pos_reg, neg_reg, regul_reg;

    // sequencer
    logic [3:0]         state_reg, state_next;
    logic [NC_W-1:0]    i_reg, i_next;
    logic [NC_W-1:0]    end_reg, end_next;
    logic [OFS_W-1:0]   j_reg, j_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [SW_W-1:0]    sweeps_reg, sweeps_next;
    logic               chg_reg, chg_next, hit_reg, hit_next;
    logic               emode_reg, emode_next;
    logic               nbok_reg, nbok_next, oob_reg, oob_next;
    logic signed [15:0] cur_reg, cur_next;
    logic               m_valid_reg, m_valid_next;
    resp_t              m_data_reg, m_data_next;

    // memories and read data
    logic signed [15:0] thr_mem [MAX_NODES];
    logic [OFS_W-1:0]   off_mem [MAX_NODES+1];
    logic [9:0]         nb_mem  [MAX_EDGES];
    logic signed [15:0] wt_mem  [MAX_EDGES];
    logic signed [15:0] st_mem  [MAX_NODES];

    logic signed [15:0] thr_q, wt_q, st_q;
    logic [OFS_W-1:0]   off_lo_q, off_hi_q;
    logic [9:0]         nb_q;

    logic               thr_we, off_we, e_we, st_we, node_re, e_re, st_re;
    logic [NA-1:0]      st_waddr, st_raddr;
    logic signed [15:0] st_wdata;

    mac_ctl_t                mac_ctl;
    logic signed [16:0]      mac_a;
    logic signed [15:0]      mac_b;
    logic signed [ACC_W-1:0] acc;

    logic [NC_W-1:0]    n_use;
    logic               accept, out_free, last_node, chg_now;
    logic signed [15:0] new_state, sn;
    logic [31:0]        hi_clip;

    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // nodes in use, capped at the store depth
    assign n_use = ({21'd0, num_nodes_reg} > 32'(MAX_NODES)) ? NC_W'(MAX_NODES)
                                                             : NC_W'(num_nodes_reg);
    assign last_node = (32'(i_reg) + 32'd1) >= 32'(n_use);

    // end offset clipped to the edge store
    assign hi_clip = (32'(off_hi_q) > 32'(MAX_EDGES)) ? 32'(MAX_EDGES) : 32'(off_hi_q);

    assign new_state = acc[ACC_W-1] ? neg_reg : pos_reg;
    assign chg_now   = chg_reg || (new_state != cur_reg);
    assign sn        = nbok_reg ? st_q : 16'sd0;

    // ---------------- config port ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_nodes_reg <= '0;
            pos_reg       <= POS_STATE_RST;
            neg_reg       <= NEG_STATE_RST;
            regul_reg     <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_NUM_NODES: num_nodes_reg <= pwdata[10:0];
                REG_POS_STATE: pos_reg       <= pwdata[15:0];
                REG_NEG_STATE: neg_reg       <= pwdata[15:0];
                REG_REGUL:     regul_reg     <= pwdata[15:0];
                default:       num_nodes_reg <= num_nodes_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_NUM_NODES: prdata = {21'd0, num_nodes_reg};
            REG_POS_STATE: prdata = {{16{pos_reg[15]}}, pos_reg};
            REG_NEG_STATE: prdata = {{16{neg_reg[15]}}, neg_reg};
            REG_REGUL:     prdata = {{16{regul_reg[15]}}, regul_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        end_next     = end_reg;
        j_next       = j_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        sweeps_next  = sweeps_reg;
        chg_next     = chg_reg;
        hit_next     = hit_reg;
        emode_next   = emode_reg;
        nbok_next    = nbok_reg;
        oob_next     = oob_reg;
        cur_next     = cur_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        thr_we   = 1'b0;
        off_we   = 1'b0;
        e_we     = 1'b0;
        st_we    = 1'b0;
        node_re  = 1'b0;
        e_re     = 1'b0;
        st_re    = 1'b0;
        st_waddr = i_reg[NA-1:0];
        st_raddr = i_reg[NA-1:0];
        st_wdata = 16'sd0;
        mac_ctl  = '0;
        mac_a    = '0;
        mac_b    = '0;

        unique case (state_reg)
            ST_CLR: begin
                st_we  = 1'b1;
                i_next = i_reg + 1'b1;
                if ((32'(i_reg) + 32'd1) >= 32'(end_reg)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.req_type)
                        REQ_WRITE_NODE: begin
                            thr_we = (32'(s_data.node_index) < 32'(MAX_NODES));
                            off_we = (32'(s_data.node_index) <= 32'(MAX_NODES));
                        end
                        REQ_WRITE_EDGE: begin
                            e_we = (32'(s_data.edge_index) < 32'(MAX_EDGES));
                        end
                        REQ_SET_STATE: begin
                            st_we    = (32'(s_data.node_index) < 32'(MAX_NODES));
                            st_waddr = NA'(s_data.node_index);
                            st_wdata = s_data.init_state;
                        end
                        REQ_RUN: begin
                            sweeps_next = SW_W'(1);
                            chg_next    = 1'b0;
                            hit_next    = 1'b0;
                            emode_next  = 1'b0;
                            i_next      = '0;
                            mac_ctl.clr = 1'b1;
                            state_next  = (n_use == '0) ? ST_DONE : ST_NODE;
                        end
                        REQ_READ_STATE: begin
                            st_re      = 1'b1;
                            st_raddr   = NA'(s_data.node_index);
                            oob_next   = (32'(s_data.node_index) >= 32'(MAX_NODES));
                            state_next = ST_RDATA;
                        end
                        REQ_CLEAR: begin
                            if (n_use != '0) begin
                                end_next   = n_use;
                                i_next     = '0;
                                state_next = ST_CLR;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RDATA: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next            = '0;
                    m_data_next.resp_kind  = RESP_READOUT;
                    m_data_next.node_state = oob_reg ? 16'sd0 : st_q;
                    state_next             = ST_IDLE;
                end
            end
            ST_NODE: begin
                node_re    = 1'b1;
                st_re      = 1'b1;
                state_next = ST_NODE2;
            end
            ST_NODE2: begin
                lo_next     = off_lo_q;
                hi_next     = (32'(off_lo_q) >= hi_clip) ? off_lo_q : OFS_W'(hi_clip);
                j_next      = off_lo_q;
                cur_next    = st_q;
                mac_ctl.mul = 1'b1;
                if (emode_reg) begin
                    mac_a = {thr_q[15], thr_q};
                    mac_b = st_q;
                end else begin
                    mac_ctl.clr = 1'b1;
                    mac_a = -{thr_q[15], thr_q};
                    mac_b = 16'sd256;
                end
                state_next = ST_NADD;
            end
            ST_NADD: begin
                mac_ctl.add = 1'b1;
                state_next  = (lo_reg < hi_reg) ? ST_ERD : ST_DECIDE;
            end
            ST_ERD: begin
                e_re       = 1'b1;
                state_next = ST_SRD;
            end
            ST_SRD: begin
                st_re      = 1'b1;
                st_raddr   = NA'(nb_q);
                nbok_next  = (32'(nb_q) < 32'(MAX_NODES));
                state_next = ST_MUL;
            end
            ST_MUL: begin
                mac_ctl.mul = 1'b1;
                if (emode_reg) begin
                    // both ends positive: subtract weight/2 in Q.16
                    mac_a = (cur_reg > 16'sd0 && sn > 16'sd0) ? -{wt_q[15], wt_q} : 17'sd0;
                    mac_b = 16'sd128;
                end else begin
                    mac_a = {wt_q[15], wt_q} - {regul_reg[15], regul_reg};
                    mac_b = sn;
                end
                state_next = ST_ADD;
            end
            ST_ADD: begin
                mac_ctl.add = 1'b1;
                j_next      = j_reg + 1'b1;
                state_next  = ((32'(j_reg) + 32'd1) < 32'(hi_reg)) ? ST_ERD : ST_DECIDE;
            end
            ST_DECIDE: begin
                if (emode_reg) begin
                    if (last_node) begin
                        state_next = ST_DONE;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_NODE;
                    end
                end else begin
                    st_we    = 1'b1;
                    st_wdata = new_state;
                    chg_next = chg_now;
                    if (!last_node) begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_NODE;
                    end else if (!chg_now || (32'(sweeps_reg) > 32'(SWEEP_LIMIT))) begin
                        // settled or out of sweeps: energy pass
                        hit_next    = chg_now;
                        emode_next  = 1'b1;
                        i_next      = '0;
                        mac_ctl.clr = 1'b1;
                        state_next  = ST_NODE;
                    end else begin
                        sweeps_next = sweeps_reg + 1'b1;
                        chg_next    = 1'b0;
                        i_next      = '0;
                        state_next  = ST_NODE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next           = '0;
                    m_data_next.resp_kind = RESP_RUN;
                    m_data_next.sweeps    = 13'(sweeps_reg);
                    m_data_next.hit_limit = hit_reg;
                    m_data_next.energy    = acc;
                    state_next            = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            i_reg       <= '0;
            end_reg     <= NC_W'(MAX_NODES);
            m_valid_reg <= 1'b0;
            sweeps_reg  <= '0;
            chg_reg     <= 1'b0;
            hit_reg     <= 1'b0;
            emode_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            end_reg     <= end_next;
            m_valid_reg <= m_valid_next;
            sweeps_reg  <= sweeps_next;
            chg_reg     <= chg_next;
            hit_reg     <= hit_next;
            emode_reg   <= emode_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg      <= j_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        nbok_reg   <= nbok_next;
        oob_reg    <= oob_next;
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
    end

    // ---------------- stores ----------------
    always_ff @(posedge aclk) begin
        if (thr_we) begin
            thr_mem[NA'(s_data.node_index)] <= s_data.threshold;
        end
        if (node_re) begin
            thr_q <= thr_mem[i_reg[NA-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (off_we) begin
            off_mem[OA'(s_data.node_index)] <= s_data.edge_start;
        end
        if (node_re) begin
            off_lo_q <= off_mem[i_reg];
            off_hi_q <= off_mem[i_reg + 1'b1];
        end
    end

    always_ff @(posedge aclk) begin
        if (e_we) begin
            nb_mem[EA'(s_data.edge_index)] <= s_data.neighbor;
            wt_mem[EA'(s_data.edge_index)] <= s_data.weight;
        end
        if (e_re) begin
            nb_q <= nb_mem[EA'(j_reg)];
            wt_q <= wt_mem[EA'(j_reg)];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (st_re) begin
            st_q <= st_mem[st_raddr];
        end
    end

    hgs_mac u_mac (
        .aclk (aclk),
        .ctl  (mac_ctl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (acc)
    );

`ifndef SYNTH
    a_edge_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ERD) |-> (j_reg < hi_reg))
        else $error("edge slot beyond node range");

    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(sweeps_reg) <= 32'(SWEEP_LIMIT) + 32'd1)
        else $error("sweep count past limit");

    a_hit_needs_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && hit_reg) |-> (32'(sweeps_reg) > 32'(SWEEP_LIMIT)))
        else $error("limit flag without exhausted sweeps");

    a_node_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NODE) |-> (i_reg < n_use))
        else $error("node index beyond nodes in use");
`endif

endmodule

@@ dv/hgs_checker.sv @@
// Checker: tracks config writes and accepted requests, predicts results and compares them.
module hgs_checker
    import hgs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  req_t        s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  resp_t       m_data,
    input  logic        wrap_up,
    output int          fail_count,
    output int          pending,
    output int          runs_seen,
    output int          limit_hits
);
    localparam int NODES     = DEF_MAX_NODES;
    localparam int EDGES     = DEF_MAX_EDGES;
    localparam int SWEEP_CAP = DEF_SWEEP_LIMIT;

    int          node_thr  [NODES];
    int unsigned edge_ofs  [NODES+1];
    int unsigned edge_nbr  [EDGES];
    int          edge_wgt  [EDGES];
    int          node_val  [NODES];

    int unsigned nodes_cfg;
    int          pos_cfg;
    int          neg_cfg;
    int          regul_cfg;

    resp_t results_due[$];
    bit    leftovers_flagged;

    initial begin
        fail_count = 0;
        runs_seen  = 0;
        limit_hits = 0;
        pending    = 0;
    end

    function automatic int val_at(int unsigned idx);
        return (idx < NODES) ? node_val[idx] : 0;
    endfunction

    // Sequential settle in index order, then energy of the final states.
    function automatic resp_t settle();
        int unsigned n, sweeps, lo, hi;
        bit          moved;
        longint      acc, nrg;
        int          prev;
        resp_t       r;
        n      = (nodes_cfg > NODES) ? NODES : nodes_cfg;
        sweeps = 0;
        moved  = 1'b1;
        while (moved) begin
            sweeps++;
            moved = 1'b0;
            for (int i = 0; i < n; i++) begin
                prev = node_val[i];
                acc  = -longint'(node_thr[i]) * 256;
                lo   = edge_ofs[i];
                hi   = (edge_ofs[i+1] > EDGES) ? EDGES : edge_ofs[i+1];
                for (int unsigned j = lo; j < hi; j++)
                    acc += longint'(edge_wgt[j] - regul_cfg) * val_at(edge_nbr[j]);
                node_val[i] = (acc < 0) ? neg_cfg : pos_cfg;
                if (node_val[i] != prev) moved = 1'b1;
            end
            if (sweeps > SWEEP_CAP) break;
        end
        nrg = 0;
        for (int i = 0; i < n; i++) begin
            nrg += longint'(node_thr[i]) * node_val[i];
            lo = edge_ofs[i];
            hi = (edge_ofs[i+1] > EDGES) ? EDGES : edge_ofs[i+1];
            for (int unsigned j = lo; j < hi; j++)
                if (node_val[i] > 0 && val_at(edge_nbr[j]) > 0)
                    nrg -= longint'(edge_wgt[j]) * 128;
        end
        r           = '0;
        r.resp_kind = RESP_RUN;
        r.sweeps    = sweeps[12:0];
        r.hit_limit = moved;
        r.energy    = nrg[47:0];
        runs_seen++;
        if (moved) limit_hits++;
        return r;
    endfunction

    task automatic report(string what, logic [47:0] got, logic [47:0] want);
        $display("MISMATCH @%0t: %s got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        resp_t want, rd;
        if (!aresetn) begin
            foreach (node_val[i]) node_val[i] = 0;
            nodes_cfg = 0;
            pos_cfg   = int'(POS_STATE_RST);
            neg_cfg   = int'(NEG_STATE_RST);
            regul_cfg = 0;
            results_due.delete();
            leftovers_flagged = 1'b0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_NUM_NODES: nodes_cfg = {21'd0, pwdata[10:0]};
                    REG_POS_STATE: pos_cfg   = int'($signed(pwdata[15:0]));
                    REG_NEG_STATE: neg_cfg   = int'($signed(pwdata[15:0]));
                    REG_REGUL:     regul_cfg = int'($signed(pwdata[15:0]));
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    report("result transaction with nothing expected", m_data.energy, '0);
                end else begin
                    want = results_due.pop_front();
                    if (m_data.resp_kind !== want.resp_kind)
                        report("resp_kind", 48'(m_data.resp_kind), 48'(want.resp_kind));
                    if (m_data.node_state !== want.node_state)
                        report("node_state", 48'(m_data.node_state), 48'(want.node_state));
                    if (m_data.sweeps !== want.sweeps)
                        report("sweeps", 48'(m_data.sweeps), 48'(want.sweeps));
                    if (m_data.hit_limit !== want.hit_limit)
                        report("hit_limit", 48'(m_data.hit_limit), 48'(want.hit_limit));
                    if (m_data.energy !== want.energy)
                        report("energy", m_data.energy, want.energy);
                end
            end
            if (s_valid && s_ready) begin
                case (s_data.req_type)
                    REQ_WRITE_NODE: begin
                        if (s_data.node_index < NODES)
                            node_thr[s_data.node_index[9:0]] = int'(s_data.threshold);
                        if (s_data.node_index <= NODES)
                            edge_ofs[s_data.node_index] = {19'd0, s_data.edge_start};
                    end
                    REQ_WRITE_EDGE: begin
                        edge_nbr[s_data.edge_index] = {22'd0, s_data.neighbor};
                        edge_wgt[s_data.edge_index] = int'(s_data.weight);
                    end
                    REQ_SET_STATE:
                        if (s_data.node_index < NODES)
                            node_val[s_data.node_index[9:0]] = int'(s_data.init_state);
                    REQ_RUN: results_due.push_back(settle());
                    REQ_READ_STATE: begin
                        rd            = '0;
                        rd.resp_kind  = RESP_READOUT;
                        rd.node_state = 16'(val_at({21'd0, s_data.node_index}));
                        results_due.push_back(rd);
                    end
                    REQ_CLEAR:
                        for (int i = 0; i < NODES && i < nodes_cfg; i++) node_val[i] = 0;
                    default: ;
                endcase
            end
            if (wrap_up && !leftovers_flagged) begin
                leftovers_flagged = 1'b1;
                foreach (results_due[i])
                    report("expected result never arrived", '0, results_due[i].energy);
            end
        end
        pending <= results_due.size();
    end

endmodule

@@ dv/hopfield_graph_settle_tb.sv @@
// Testbench top: drives loads, runs and readouts into the settle block and gives the verdict.
module hopfield_graph_settle_tb
    import hgs_pkg::*;
();

    // Request codes the block must ignore.
    localparam logic [2:0] REQ_RSVD_A = 3'd6;
    localparam logic [2:0] REQ_RSVD_B = 3'd7;

    localparam int TARGET_ITEMS = 850;
    localparam int QUIET_AFTER  = 720;
    // Gap that lets the worst clear pass, over all MAX_NODES nodes, end before config writes.
    localparam int SETTLE_GAP   = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 3000000;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    req_t        s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    resp_t       m_data;

    logic wrap_up     = 1'b0;
    bit   quiet       = 1'b0;   // no idling on either side
    bit   hold_armed  = 1'b0;   // owned by stimulus
    bit   hold_done   = 1'b0;   // owned by receiver
    int   sent        = 0;
    int   cycles      = 0;
    int   fail_count, pending, runs_seen, limit_hits;

    hopfield_graph_settle dut (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
    );

    hgs_checker u_checker (
        .aclk, .aresetn, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .wrap_up, .fail_count, .pending, .runs_seen, .limit_hits
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or runaway run ends here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("hopfield_graph_settle regression: fail");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off so that a readout
    // sits in the output register and the input side backs up behind it.
    initial begin : rx_side
        int k;
        forever begin
            @(posedge aclk);
            if (hold_armed && !hold_done) begin
                m_ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(posedge aclk);
                hold_done = 1'b1;
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Fields not used by a request carry random bits.
    function automatic req_t blank(logic [2:0] kind);
        logic [127:0] raw;
        req_t         r;
        raw        = {$urandom(), $urandom(), $urandom(), $urandom()};
        r          = raw[$bits(req_t)-1:0];
        r.req_type = kind;
        return r;
    endfunction

    // Q8.8 value: mostly modest, sometimes anywhere in the 16-bit range.
    function automatic int rnd_q88();
        if ($urandom_range(0, 3) == 0) return int'($signed(16'($urandom())));
        return int'($urandom_range(0, 1024)) - 512;
    endfunction

    // One transaction on the request channel; valid stays up across back-to-back items.
    task automatic send(req_t r);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic put_node(int idx, int thr, int ofs);
        req_t r;
        r            = blank(REQ_WRITE_NODE);
        r.node_index = 11'(idx);
        r.threshold  = 16'(thr);
        r.edge_start = 13'(ofs);
        send(r);
    endtask

    task automatic put_edge(int slot, int nb, int w);
        req_t r;
        r            = blank(REQ_WRITE_EDGE);
        r.edge_index = 12'(slot);
        r.neighbor   = 10'(nb);
        r.weight     = 16'(w);
        send(r);
    endtask

    task automatic put_state(int idx, int v);
        req_t r;
        r            = blank(REQ_SET_STATE);
        r.node_index = 11'(idx);
        r.init_state = 16'(v);
        send(r);
    endtask

    task automatic request(logic [2:0] kind, int idx);
        req_t r;
        r            = blank(kind);
        r.node_index = 11'(idx);
        send(r);
    endtask

    task automatic cfg_write(logic [1:0] sel, int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= 32'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait for every expected result, then for any trailing clear pass.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_GAP) @(posedge aclk);
    endtask

    task automatic noise(int n);
        case ($urandom_range(0, 4))
            0: request($urandom_range(0, 1) ? REQ_RSVD_A : REQ_RSVD_B, $urandom_range(0, 2047));
            1: put_node($urandom_range(1025, 2047), rnd_q88(), $urandom_range(0, 8191));
            2: put_node($urandom_range(n + 1, 1024), rnd_q88(), $urandom_range(0, 8191));
            3: put_state($urandom_range(1024, 2047), rnd_q88());
            default: request(REQ_READ_STATE, $urandom_range(1024, 2047));
        endcase
    endtask

    // One random graph: nodes point only at lower-index nodes or at nodes outside the
    // active range, so a run settles in at most two sweeps. Occasional shrinking
    // offsets give nodes with no edges.
    task automatic episode(int ep_no);
        int          n, lo, hi, nb;
        int unsigned ofs[0:12];
        bit          slot_done[int];
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        cfg_write(REG_NUM_NODES, n);
        if ($urandom_range(0, 2) == 0) begin
            cfg_write(REG_POS_STATE, rnd_q88());
            cfg_write(REG_NEG_STATE, rnd_q88());
            cfg_write(REG_REGUL, ($urandom_range(0, 1) ? rnd_q88() : 0));
        end
        ofs[0] = $urandom_range(0, 4000);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0 && ofs[i] >= 2)
                ofs[i+1] = ofs[i] - $urandom_range(1, 2);
            else
                ofs[i+1] = ofs[i] + $urandom_range(0, 4);
        end
        for (int i = 0; i <= n; i++) begin
            put_node(i, rnd_q88(), ofs[i]);
            if ($urandom_range(0, 9) == 0) noise(n);
        end
        for (int i = 0; i < n; i++) begin
            lo = ofs[i];
            hi = (ofs[i+1] > DEF_MAX_EDGES) ? DEF_MAX_EDGES : ofs[i+1];
            for (int s = lo; s < hi; s++) begin
                if (!slot_done.exists(s)) begin
                    slot_done[s] = 1'b1;
                    nb = (i > 0 && $urandom_range(0, 2) != 0) ? $urandom_range(0, i - 1)
                                                              : $urandom_range(n, 1023);
                    put_edge(s, nb, rnd_q88());
                end
            end
        end
        if ($urandom_range(0, 3) == 0) request(REQ_CLEAR, 0);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 2) != 0) put_state(i, rnd_q88());
        if ($urandom_range(0, 1)) put_state($urandom_range(n, 1023), rnd_q88());
        request(REQ_RUN, 0);
        if (ep_no == 4) hold_armed = 1'b1;
        for (int k = $urandom_range(1, n + 2); k > 0; k--) begin
            request(REQ_READ_STATE, ($urandom_range(0, 5) == 0) ? $urandom_range(n, 2047)
                                                                : $urandom_range(0, n - 1));
            if ($urandom_range(0, 7) == 0) noise(n);
        end
        // Pressure episode: keep offering reads while the receiver holds off.
        if (ep_no == 4)
            for (int k = 0; k < 10; k++) request(REQ_READ_STATE, $urandom_range(0, n - 1));
        if ($urandom_range(0, 3) == 0) begin
            request(REQ_RUN, 0);
            request(REQ_READ_STATE, $urandom_range(0, n - 1));
        end
        if ($urandom_range(0, 5) == 0) begin
            request(REQ_CLEAR, 0);
            request(REQ_READ_STATE, $urandom_range(0, n - 1));
        end
        drain();
    endtask

    initial begin : stim
        int ep_no;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty stores, out-of-range indexes, ignored codes, empty graph.
        request(REQ_READ_STATE, 0);
        request(REQ_READ_STATE, 2047);
        put_state(1500, 16'sh7fff);
        request(REQ_RSVD_A, 0);
        request(REQ_RSVD_B, 0);
        put_node(2047, -32768, 8191);
        request(REQ_RUN, 0);
        request(REQ_CLEAR, 0);
        drain();

        // Oversized node count acts as the full store; clear walks all of it.
        cfg_write(REG_NUM_NODES, 2047);
        cfg_write(REG_REGUL, 0);
        request(REQ_CLEAR, 0);
        request(REQ_READ_STATE, 1023);
        drain();

        // Field extremes, edge range clipped at the top of the edge store.
        cfg_write(REG_NUM_NODES, 2);
        cfg_write(REG_POS_STATE, 32767);
        cfg_write(REG_NEG_STATE, -32768);
        cfg_write(REG_REGUL, -32768);
        put_node(0, 32767, 4090);
        put_node(1, -32768, 4093);
        put_node(2, 0, 8191);
        put_node(1024, 0, 4096);
        put_edge(4090, 1023, -32768);
        put_edge(4091, 1022, 32767);
        put_edge(4092, 1023, 32767);
        put_edge(4093, 0, -32768);
        put_edge(4094, 1023, 32767);
        put_edge(4095, 0, 0);
        put_state(1023, 32767);
        put_state(1022, -32768);
        request(REQ_RUN, 0);
        request(REQ_READ_STATE, 0);
        request(REQ_READ_STATE, 1);
        drain();

        // Self-inhibiting node flips every sweep: the run stops at the sweep limit.
        cfg_write(REG_NUM_NODES, 1);
        cfg_write(REG_POS_STATE, 256);
        cfg_write(REG_NEG_STATE, -256);
        cfg_write(REG_REGUL, 0);
        put_node(0, 0, 100);
        put_node(1, 0, 101);
        put_edge(100, 0, -256);
        put_state(0, 256);
        request(REQ_RUN, 0);
        request(REQ_READ_STATE, 0);
        drain();

        // Random graphs; the tail of the run goes without idling.
        ep_no = 0;
        while (sent < TARGET_ITEMS) begin
            if (sent > QUIET_AFTER) quiet = 1'b1;
            episode(ep_no);
            ep_no++;
        end

        wrap_up <= 1'b1;
        repeat (4) @(posedge aclk);
        $display("%0d request transactions over %0d graphs, %0d runs (%0d stopped at sweep limit)",
                 sent, ep_no, runs_seen, limit_hits);
        if (fail_count == 0) begin
            $display("hopfield_graph_settle regression: pass");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("hopfield_graph_settle regression: fail");
        end
        $finish;
    end

endmodule
